// ===== rtl/prpe_pkg.sv =====
// ----------------------------------------------------------------------------
// prpe_pkg
// Shared types and constants of the pcap RTP payload extractor.
// ----------------------------------------------------------------------------
package prpe_pkg;

	// Parser phases of the byte stream.
	typedef enum logic [3:0] {
		PH_FILE    = 4'd0,
		PH_REC     = 4'd1,
		PH_ETH     = 4'd2,
		PH_IP      = 4'd3,
		PH_UDP     = 4'd4,
		PH_RTP     = 4'd5,
		PH_CSRC    = 4'd6,
		PH_PAYLOAD = 4'd7,
		PH_SKIP    = 4'd8
	} phase_t;

	// Configuration register indexes.
	localparam logic REG_SRC_IP = 1'b0;
	localparam logic REG_DST_IP = 1'b1;

	localparam logic [7:0]  IP_PROTO_UDP = 8'd17;
	localparam logic [6:0]  PT_PCMU      = 7'd0;
	localparam logic [6:0]  PT_MPA       = 7'd14;
	localparam logic [6:0]  PT_VIDEO     = 7'd96;
	localparam logic [31:0] USEC_PER_SEC = 32'd1000000;

	// One forwarded payload word.
	typedef struct packed {
		logic        last_byte;
		logic [31:0] pts;
		logic        pts_valid;
		logic        marker_bit;
		logic [6:0]  payload_kind;
		logic        channel;
		logic [7:0]  payload_byte;
	} result_t;

endpackage

// ===== rtl/pcap_rtp_payload_extractor.sv =====
// ----------------------------------------------------------------------------
// pcap_rtp_payload_extractor
// Parses a little-endian pcap byte stream and forwards RTP payload bytes of
// selected IPv4/UDP packets with stream timestamps.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                  Contents
// s_axis    in         s_axis_tvalid/tready       data_byte
// m_axis    out        m_axis_tvalid/tready       payload word (see tdata/tuser)
// cfg       in         cfg_we                     src_ip, dst_ip
//
// One byte is accepted per cycle; each result appears in the cycle after the
// byte that causes it, from a single output register.
// The pts product sits in one register stage that reads record times and
// origins that are stable long before the payload. A packet that latches a
// new origin has a pts of zero, so the first payload byte may directly
// follow the RTP header.
// Input stalls only while the output register holds an untaken word.
// Reset clears all parser state and both stream origins.
// ----------------------------------------------------------------------------
module pcap_rtp_payload_extractor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // [7:0] payload_byte, [8] marker_bit,
	                                    // [9] pts_valid, [41:10] pts, [47:42] zero
	output logic [7:0]  m_axis_tuser,   // [0] channel, [7:1] payload_kind
	output logic        m_axis_tlast,   // last_byte
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [31:0] cfg_wdata
);

	prpe_pkg::phase_t phase_q;
	logic [31:0] pos_q, reclen_q, sec_q, usec_q, cap_q;
	logic [15:0] udplen_q, left_q, flags_q;
	logic        match_q, seqv_q, aset_q, vset_q;
	logic [15:0] seq_q, prev_seq_q;
	logic [31:0] asec_q, ausec_q, vsec_q, vusec_q, src_q, dst_q;
	logic        ptsvid_q, ptsen_q, ptszero_q;
	logic [31:0] el_a, el_v;
	prpe_pkg::result_t res_q;
	logic        ovalid_q;

	logic acc;
	assign s_axis_tready = !ovalid_q || m_axis_tready;
	assign acc = s_axis_tvalid && s_axis_tready;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_q <= '0;
			dst_q <= '0;
		end else if (cfg_we) begin
			if (cfg_addr == prpe_pkg::REG_SRC_IP) src_q <= cfg_wdata;
			else dst_q <= cfg_wdata;
		end
	end

	prpe_pts_calc u_pa (.clk, .sec(sec_q), .usec(usec_q),
		.origin_sec(asec_q), .origin_usec(ausec_q), .elapsed(el_a));
	prpe_pts_calc u_pv (.clk, .sec(sec_q), .usec(usec_q),
		.origin_sec(vsec_q), .origin_usec(vusec_q), .elapsed(el_v));

	// Combinational decode of header fields.
	logic [7:0]  b;
	logic [6:0]  pt;
	logic        mk;
	logic [3:0]  cc;
	logic [16:0] need;
	logic [31:0] cap_sh;
	logic [31:0] pts_cur;
	logic [15:0] left_m1;
	logic [31:0] rec_m1;
	assign b       = s_axis_tdata;
	assign pt      = flags_q[6:0];
	assign mk      = flags_q[7];
	assign cc      = flags_q[11:8];
	assign need    = 17'd20 + {11'd0, cc, 2'b00};
	assign cap_sh  = {b, cap_q[31:8]};
	assign pts_cur = (!ptsen_q || ptszero_q) ? 32'd0 : (ptsvid_q ? el_v : el_a);
	assign left_m1 = left_q - 16'd1;
	assign rec_m1  = reclen_q - 32'd1;

	// Parser state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= prpe_pkg::PH_FILE;
			{pos_q, reclen_q, sec_q, usec_q, cap_q} <= '0;
			{udplen_q, left_q, flags_q, seq_q, prev_seq_q} <= '0;
			{match_q, seqv_q, aset_q, vset_q, ptsvid_q, ptsen_q, ptszero_q} <= '0;
			{asec_q, ausec_q, vsec_q, vusec_q} <= '0;
		end else if (acc) begin
			if (phase_q == prpe_pkg::PH_FILE) begin
				pos_q <= pos_q + 32'd1;
				if (pos_q >= 32'd23) begin
					pos_q   <= '0;
					phase_q <= prpe_pkg::PH_REC;
				end
			end else if (phase_q == prpe_pkg::PH_REC) begin
				cap_q <= cap_sh;
				if (pos_q == 32'd3) sec_q <= cap_sh;
				if (pos_q == 32'd7) usec_q <= cap_sh;
				if (pos_q == 32'd11) reclen_q <= cap_sh;
				pos_q <= pos_q + 32'd1;
				if (pos_q >= 32'd15) begin
					pos_q   <= '0;
					phase_q <= (reclen_q != 32'd0) ? prpe_pkg::PH_ETH : prpe_pkg::PH_REC;
				end
			end else begin
				reclen_q <= rec_m1;
				pos_q    <= pos_q + 32'd1;
				case (phase_q)
					prpe_pkg::PH_ETH: begin
						if (pos_q >= 32'd13) begin
							pos_q <= '0; match_q <= 1'b1; phase_q <= prpe_pkg::PH_IP;
						end
					end
					prpe_pkg::PH_IP: begin
						logic bad;
						bad = (pos_q == 32'd9 && b != prpe_pkg::IP_PROTO_UDP)
							|| (pos_q == 32'd12 && b != src_q[31:24])
							|| (pos_q == 32'd13 && b != src_q[23:16])
							|| (pos_q == 32'd14 && b != src_q[15:8])
							|| (pos_q == 32'd15 && b != src_q[7:0])
							|| (pos_q == 32'd16 && b != dst_q[31:24])
							|| (pos_q == 32'd17 && b != dst_q[23:16])
							|| (pos_q == 32'd18 && b != dst_q[15:8])
							|| (pos_q == 32'd19 && b != dst_q[7:0]);
						if (bad) match_q <= 1'b0;
						if (pos_q >= 32'd19) begin
							pos_q   <= '0;
							phase_q <= (match_q && !bad) ? prpe_pkg::PH_UDP
								: prpe_pkg::PH_SKIP;
						end
					end
					prpe_pkg::PH_UDP: begin
						if (pos_q == 32'd4) udplen_q[15:8] <= b;
						if (pos_q == 32'd5) udplen_q[7:0] <= b;
						if (pos_q >= 32'd7) begin
							pos_q <= '0; phase_q <= prpe_pkg::PH_RTP;
						end
					end
					prpe_pkg::PH_RTP: begin
						if (pos_q == 32'd0) flags_q[15:8] <= b;
						if (pos_q == 32'd1) flags_q[7:0] <= b;
						if (pos_q == 32'd2) seq_q[15:8] <= b;
						if (pos_q == 32'd3) seq_q[7:0] <= b;
						if (pos_q >= 32'd11) begin
							pos_q <= '0;
							if (flags_q[15:14] != 2'd2 || (seqv_q && seq_q == prev_seq_q)
								|| {1'b0, udplen_q} < need) begin
								phase_q <= prpe_pkg::PH_SKIP;
							end else begin
								seqv_q     <= 1'b1;
								prev_seq_q <= seq_q;
								left_q     <= 16'(udplen_q - need[15:0]);
								ptsvid_q   <= (pt == prpe_pkg::PT_VIDEO);
								ptsen_q    <= (pt != prpe_pkg::PT_VIDEO) || mk;
								// A packet that sets its stream origin is at time zero.
								ptszero_q  <= ((pt == prpe_pkg::PT_PCMU
									|| pt == prpe_pkg::PT_MPA) && !aset_q)
									|| (pt == prpe_pkg::PT_VIDEO && mk && !vset_q);
								if (pt == prpe_pkg::PT_PCMU || pt == prpe_pkg::PT_MPA) begin
									if (!aset_q) begin
										aset_q <= 1'b1; asec_q <= sec_q; ausec_q <= usec_q;
									end
								end else if (pt == prpe_pkg::PT_VIDEO) begin
									if (mk && !vset_q) begin
										vset_q <= 1'b1; vsec_q <= sec_q; vusec_q <= usec_q;
									end
								end
								if (!(pt == prpe_pkg::PT_PCMU || pt == prpe_pkg::PT_MPA
									|| pt == prpe_pkg::PT_VIDEO) || udplen_q == need[15:0])
									phase_q <= prpe_pkg::PH_SKIP;
								else
									phase_q <= (cc != 4'd0) ? prpe_pkg::PH_CSRC
										: prpe_pkg::PH_PAYLOAD;
							end
						end
					end
					prpe_pkg::PH_CSRC: begin
						if (pos_q + 32'd1 >= {26'd0, cc, 2'b00}) begin
							pos_q <= '0; phase_q <= prpe_pkg::PH_PAYLOAD;
						end
					end
					prpe_pkg::PH_PAYLOAD: begin
						left_q <= left_m1;
						if (left_m1 == 16'd0) phase_q <= prpe_pkg::PH_SKIP;
					end
					default: phase_q <= prpe_pkg::PH_SKIP;
				endcase
				if (rec_m1 == 32'd0) begin
					pos_q <= '0; phase_q <= prpe_pkg::PH_REC;
				end
			end
		end
	end

	// Result register.
	logic fwd;
	assign fwd = acc && phase_q == prpe_pkg::PH_PAYLOAD
		&& !(pt == prpe_pkg::PT_MPA && pos_q < 32'd4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ovalid_q <= 1'b0;
		else if (s_axis_tready) ovalid_q <= fwd;
	end

	always_ff @(posedge clk) begin
		if (fwd) begin
			res_q.payload_byte <= b;
			res_q.channel      <= (pt == prpe_pkg::PT_VIDEO);
			res_q.payload_kind <= pt;
			res_q.marker_bit   <= mk;
			res_q.pts_valid    <= ptsen_q;
			res_q.pts          <= pts_cur;
			res_q.last_byte    <= (left_m1 == 16'd0) || (rec_m1 == 32'd0);
		end
	end

	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = {6'd0, res_q.pts, res_q.pts_valid, res_q.marker_bit,
		res_q.payload_byte};
	assign m_axis_tuser  = {res_q.payload_kind, res_q.channel};
	assign m_axis_tlast  = res_q.last_byte;

	// Output word holds while stalled.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("word dropped");
	// Nothing is forwarded outside the payload phase.
	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		fwd |-> phase_q == prpe_pkg::PH_PAYLOAD) else $error("stray word");
	// Input stalls only behind a waiting word.
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid) else $error("needless stall");

endmodule

// ===== rtl/prpe_pts_calc.sv =====
// ----------------------------------------------------------------------------
// prpe_pts_calc
// Registered presentation time: elapsed microseconds between a record time
// and a stream origin, one multiply in the first stage.
// ----------------------------------------------------------------------------
module prpe_pts_calc (
	input  logic        clk,
	input  logic [31:0] sec,
	input  logic [31:0] usec,
	input  logic [31:0] origin_sec,
	input  logic [31:0] origin_usec,
	output logic [31:0] elapsed
);

	logic [31:0] sec_part_s1;
	logic [31:0] usec_part_s1;

	// Seconds scaled to microseconds, truncated to 32 bits.
	always_ff @(posedge clk) begin
		sec_part_s1  <= 32'((sec - origin_sec) * prpe_pkg::USEC_PER_SEC);
		usec_part_s1 <= usec - origin_usec;
	end

	assign elapsed = sec_part_s1 + usec_part_s1;

endmodule
